// File: hw/rtl/tklrc_pkg.sv
`default_nettype none

package tklrc_pkg;

   localparam int TIME_WIDTH  = 40;
   localparam int NUM_KEYS    = 3;
   localparam int MAX_RESULTS = NUM_KEYS;
   localparam int QDEPTH      = 6;
   localparam int CNT_W       = $clog2(QDEPTH + 1);
   localparam int IDX_W       = $clog2(QDEPTH);
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int DELTA_W     = 32;
   localparam int CODE_W      = 3;

   typedef logic [CODE_W-1:0] key_code_type;

   localparam key_code_type CODE_DOWN  = 3'd0;
   localparam key_code_type CODE_UP    = 3'd1;
   localparam key_code_type CODE_ENTER = 3'd2;
   localparam key_code_type CODE_S     = 3'd3;
   localparam key_code_type CODE_E     = 3'd4;
   localparam key_code_type CODE_SPACE = 3'd5;

   // register index = paddr[4:2]
   localparam logic [2:0] REG_KEY_ENABLE      = 3'd0;
   localparam logic [2:0] REG_DOWN_ACTIVE_LOW = 3'd1;
   localparam logic [2:0] REG_REPEAT_INTERVAL = 3'd2;
   localparam logic [2:0] REG_LONGPRESS       = 3'd3;
   localparam logic [2:0] REG_RELEASE_GUARD   = 3'd4;

   localparam logic [NUM_KEYS-1:0] RST_KEY_ENABLE      = 3'd7;
   localparam logic                RST_DOWN_ACTIVE_LOW = 1'b0;
   localparam logic [31:0]         RST_REPEAT_INTERVAL = 32'd200000000;
   localparam logic [31:0]         RST_LONGPRESS       = 32'd500000000;
   localparam logic [31:0]         RST_RELEASE_GUARD   = 32'd10000000;

   typedef struct packed {
      logic [31:0] repeat_interval;
      logic [31:0] longpress;
      logic [31:0] release_guard;
   } lane_cfg_type;

   typedef struct packed {
      logic         valid;
      key_code_type code;
   } lane_emit_type;

   typedef struct packed {
      key_code_type code;
      logic         last;
   } rsp_entry_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             has_room;
   } queue_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/tklrc_if.sv
`default_nettype none

interface tklrc_req_if;
   import tklrc_pkg::*;
   logic               valid;
   logic               ready;
   logic               down_level;
   logic               up_pressed;
   logic               power_pressed;
   logic [DELTA_W-1:0] elapsed_ns;

   modport source (output valid, down_level, up_pressed, power_pressed, elapsed_ns,
                   input ready);
   modport sink   (input valid, down_level, up_pressed, power_pressed, elapsed_ns,
                   output ready);
endinterface

interface tklrc_rsp_if;
   import tklrc_pkg::*;
   logic         valid;
   logic         ready;
   key_code_type key_code;
   logic         last;

   modport source (output valid, key_code, last, input ready);
   modport sink   (input valid, key_code, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tklrc_lane.sv
`default_nettype none

module tklrc_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   pressed,
   input  wire logic [31:0]            delta,
   input  wire logic                   is_power,
   input  wire tklrc_pkg::key_code_type own_code,
   input  wire tklrc_pkg::key_code_type long_code,
   input  wire logic                   block_long,
   input  wire tklrc_pkg::lane_cfg_type cfg,
   output tklrc_pkg::lane_emit_type    emit,
   output logic                        down_flag
);
   import tklrc_pkg::*;

   typedef enum logic [1:0] {
      PH_RELEASED,
      PH_PRESSED,
      PH_PENDING
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]   held_ff, held_in;
   logic                    rep_ff, rep_in;
   logic                    long_ff, long_in;
   logic                    flag_ff, flag_in;

   logic [TIME_WIDTH:0]     sum;
   logic [TIME_WIDTH-1:0]   t;
   logic                    ge_repeat, ge_long, ge_guard;

   always_comb begin
      sum = {1'b0, held_ff} + {{(TIME_WIDTH + 1 - DELTA_W){1'b0}}, delta};
      t   = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
      ge_repeat = t >= {{(TIME_WIDTH - 32){1'b0}}, cfg.repeat_interval};
      ge_long   = t >= {{(TIME_WIDTH - 32){1'b0}}, cfg.longpress};
      ge_guard  = t >= {{(TIME_WIDTH - 32){1'b0}}, cfg.release_guard};

      phase_in   = phase_ff;
      held_in    = t;
      rep_in     = rep_ff;
      long_in    = long_ff;
      flag_in    = pressed;
      emit.valid = 1'b0;
      emit.code  = own_code;

      case (phase_ff)
         PH_PRESSED: begin
            if (pressed) begin
               if (rep_ff && ge_repeat) begin
                  emit.valid = 1'b1;
                  held_in    = '0;
               end else if (!long_ff && ge_long) begin
                  if (is_power) begin
                     emit.valid = 1'b1;
                     emit.code  = long_code;
                  end else if (!block_long) begin
                     // volume key starts autorepeat unless power is held
                     emit.valid = 1'b1;
                     held_in    = '0;
                     rep_in     = 1'b1;
                  end
                  long_in = 1'b1;
               end
            end else begin
               if (!long_ff) begin
                  emit.valid = 1'b1;
                  phase_in   = PH_PENDING;
               end else if (ge_guard) begin
                  held_in  = '0;
                  rep_in   = 1'b0;
                  long_in  = 1'b0;
                  phase_in = PH_RELEASED;
               end
            end
         end
         PH_PENDING: begin
            // always back to released, a press on this tick is dropped
            held_in  = '0;
            rep_in   = 1'b0;
            long_in  = 1'b0;
            phase_in = PH_RELEASED;
         end
         default: begin
            if (pressed) begin
               held_in  = '0;
               phase_in = PH_PRESSED;
            end else begin
               phase_in = PH_RELEASED;
            end
         end
      endcase

      if (!step) begin
         emit.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         held_ff  <= '0;
         rep_ff   <= 1'b0;
         long_ff  <= 1'b0;
         flag_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         rep_ff   <= rep_in;
         long_ff  <= long_in;
         flag_ff  <= flag_in;
      end
   end

   assign down_flag = flag_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tklrc_merge.sv
`default_nettype none

module tklrc_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire tklrc_pkg::lane_emit_type emit [tklrc_pkg::NUM_KEYS],
   input  wire logic                     pop,
   output tklrc_pkg::rsp_entry_type      head,
   output tklrc_pkg::queue_status_type   status
);
   import tklrc_pkg::*;

   rsp_entry_type    q_ff [QDEPTH];
   rsp_entry_type    q_in [QDEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_entry_type    items [MAX_RESULTS];
   logic [NRES_W-1:0] n;
   logic [CNT_W-1:0] base;

   always_comb begin
      n = '0;
      for (int j = 0; j < MAX_RESULTS; j++) begin
         items[j].code = CODE_DOWN;
         items[j].last = 1'b0;
      end
      // pack the lane reports in key order
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (emit[k].valid) begin
            items[n[NRES_W-1:0]].code = emit[k].code;
            n = n + NRES_W'(1);
         end
      end
      for (int j = 0; j < MAX_RESULTS; j++) begin
         items[j].last = (NRES_W'(j) == n - NRES_W'(1));
      end

      base = count_ff - CNT_W'(pop);
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      if (push) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (NRES_W'(j) < n) begin
               q_in[IDX_W'(base + CNT_W'(j))] = items[j];
            end
         end
      end
      count_in = base + (push ? CNT_W'(n) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign head            = q_ff[0];
   assign status.count    = count_ff;
   assign status.has_room = count_ff <= CNT_W'(QDEPTH - MAX_RESULTS);

endmodule

`default_nettype wire

// File: hw/rtl/three_key_longpress_repeat_combo.sv
// Three-key long-press / autorepeat / combo detector.
// req: one item per poll tick with the volume down raw level, volume up and
//   power pressed levels, and the nanoseconds since the previous tick.
// rsp: zero to three key reports per tick (key_code 0..5), in key order
//   down, up, power; last marks the final report of a tick. A tick that
//   reports nothing produces no rsp item.
// Timing: the three key lanes update in the accept cycle; reports sit in a
//   6-entry result queue and rsp.valid rises the cycle after the accept.
//   One tick is accepted per cycle while the queue has room for three more
//   reports; sustained throughput is bound by the single rsp port, one
//   report per cycle.
// Receiver stall: reports wait in the queue; req.ready drops once fewer
//   than three slots remain free, no report is lost.
// Config: APB registers at 4*i (key_enable, down_active_low,
//   repeat_interval_ns, longpress_ns, release_guard_ns); write only while
//   idle. pready is always high.
// Reset (synchronous): all keys released, timers and flags cleared, queue
//   empty, registers at their defaults.
`default_nettype none

module three_key_longpress_repeat_combo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tklrc_req_if.sink                             req,
   tklrc_rsp_if.source                           rsp,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [tklrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tklrc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [tklrc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import tklrc_pkg::*;

   logic [NUM_KEYS-1:0] key_enable_ff;
   logic                down_active_low_ff;
   logic [31:0]         repeat_interval_ff;
   logic [31:0]         longpress_ff;
   logic [31:0]         release_guard_ff;

   logic                csr_write;
   logic [2:0]          reg_index;
   lane_cfg_type        lane_cfg;

   logic                accept;
   logic                pop;
   logic [NUM_KEYS-1:0] lvl;
   logic [NUM_KEYS-1:0] flags;
   logic [NUM_KEYS-1:0] now_down;
   logic [NUM_KEYS-1:0] is_power;
   logic [NUM_KEYS-1:0] block_long;
   key_code_type        own_code  [NUM_KEYS];
   key_code_type        long_code [NUM_KEYS];
   lane_emit_type       emit      [NUM_KEYS];
   logic                emit_any;
   rsp_entry_type       head;
   queue_status_type    qstat;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_enable_ff      <= RST_KEY_ENABLE;
         down_active_low_ff <= RST_DOWN_ACTIVE_LOW;
         repeat_interval_ff <= RST_REPEAT_INTERVAL;
         longpress_ff       <= RST_LONGPRESS;
         release_guard_ff   <= RST_RELEASE_GUARD;
      end else if (csr_write) begin
         case (reg_index)
            REG_KEY_ENABLE:      key_enable_ff      <= pwdata[NUM_KEYS-1:0];
            REG_DOWN_ACTIVE_LOW: down_active_low_ff <= pwdata[0];
            REG_REPEAT_INTERVAL: repeat_interval_ff <= pwdata[31:0];
            REG_LONGPRESS:       longpress_ff       <= pwdata[31:0];
            REG_RELEASE_GUARD:   release_guard_ff   <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_KEY_ENABLE:      prdata = {{(CSR_DATA_W - NUM_KEYS){1'b0}}, key_enable_ff};
         REG_DOWN_ACTIVE_LOW: prdata = {{(CSR_DATA_W - 1){1'b0}}, down_active_low_ff};
         REG_REPEAT_INTERVAL: prdata = repeat_interval_ff;
         REG_LONGPRESS:       prdata = longpress_ff;
         REG_RELEASE_GUARD:   prdata = release_guard_ff;
         default:             prdata = '0;
      endcase
   end

   assign lane_cfg.repeat_interval = repeat_interval_ff;
   assign lane_cfg.longpress       = longpress_ff;
   assign lane_cfg.release_guard   = release_guard_ff;

   // ---------------- key lanes ----------------
   assign accept = req.valid && req.ready;
   assign lvl    = {req.power_pressed, req.up_pressed,
                    req.down_level ^ down_active_low_ff};

   // a disabled key keeps its old down flag
   assign now_down = (key_enable_ff & lvl) | (~key_enable_ff & flags);

   always_comb begin
      own_code[0]   = CODE_DOWN;
      own_code[1]   = CODE_UP;
      own_code[2]   = CODE_ENTER;
      long_code[0]  = CODE_DOWN;
      long_code[1]  = CODE_UP;
      if (now_down[0]) begin
         long_code[2] = CODE_S;
      end else if (now_down[1]) begin
         long_code[2] = CODE_E;
      end else begin
         long_code[2] = CODE_SPACE;
      end
      is_power      = 3'b100;
      // volume keys see power as it stood after the previous tick
      block_long    = {1'b0, flags[2], flags[2]};
   end

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      tklrc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .step       (accept && key_enable_ff[k]),
         .pressed    (lvl[k]),
         .delta      (req.elapsed_ns),
         .is_power   (is_power[k]),
         .own_code   (own_code[k]),
         .long_code  (long_code[k]),
         .block_long (block_long[k]),
         .cfg        (lane_cfg),
         .emit       (emit[k]),
         .down_flag  (flags[k])
      );
   end

   assign emit_any = emit[0].valid || emit[1].valid || emit[2].valid;

   // ---------------- merge and result queue ----------------
   assign pop = rsp.valid && rsp.ready;

   tklrc_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .emit   (emit),
      .pop    (pop),
      .head   (head),
      .status (qstat)
   );

   assign req.ready    = qstat.has_room;
   assign rsp.valid    = qstat.count != '0;
   assign rsp.key_code = head.code;
   assign rsp.last     = head.last;

   // ---------------- checks ----------------
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      qstat.count <= CNT_W'(QDEPTH))
      else $error("result queue count beyond depth");

   a_full_has_data : assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("input stalled with nothing to deliver");

   a_report_shows : assert property (@(posedge clock) disable iff (reset)
      accept && emit_any |=> rsp.valid)
      else $error("reported key did not reach the result port");

   a_pop_only_valid : assert property (@(posedge clock) disable iff (reset)
      pop && qstat.count == CNT_W'(1) && !(accept && emit_any) |=> !rsp.valid)
      else $error("queue did not drain on last pop");

endmodule

`default_nettype wire

// File: bench/key_report_checker.sv
module key_report_checker
   import tklrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic                  req_down_level,
   input  wire logic                  req_up_pressed,
   input  wire logic                  req_power_pressed,
   input  wire logic [DELTA_W-1:0]    req_elapsed_ns,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [CODE_W-1:0]     rsp_key_code,
   input  wire logic                  rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic                  csr_pready,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                         fail_count,
   output int                         reports_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DOWN_KEY    = 0;
   localparam int UP_KEY      = 1;
   localparam int POWER_KEY   = 2;
   localparam int SHOWN_FAILS = 10;

   typedef enum logic [1:0] {
      PHASE_RELEASED = 2'd0,
      PHASE_PRESSED  = 2'd1,
      PHASE_PENDING  = 2'd2
   } key_phase_type;

   logic [NUM_KEYS-1:0]   en_cfg;
   logic                  low_cfg;
   logic [31:0]           repeat_cfg;
   logic [31:0]           longpress_cfg;
   logic [31:0]           guard_cfg;

   key_phase_type         phase [NUM_KEYS];
   logic [TIME_WIDTH-1:0] held [NUM_KEYS];
   logic [NUM_KEYS-1:0]   repeating;
   logic [NUM_KEYS-1:0]   long_seen;
   logic [NUM_KEYS-1:0]   down_flag;

   rsp_entry_type         due_reports[$];
   rsp_entry_type         got;
   rsp_entry_type         want;
   int                    n_fail = 0;

   assign fail_count = n_fail;

   function automatic key_code_type short_code(input int k);
      case (k)
         DOWN_KEY: return CODE_DOWN;
         UP_KEY:   return CODE_UP;
         default:  return CODE_ENTER;
      endcase
   endfunction

   task automatic clear_key(input int k);
      held[k]      = '0;
      repeating[k] = 1'b0;
      long_seen[k] = 1'b0;
      phase[k]     = PHASE_RELEASED;
   endtask

   task automatic note_fail(input string msg);
      n_fail++;
      if (n_fail <= SHOWN_FAILS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Key order down, up, power; power sees the volume flags of this tick,
   // the volume keys see the power flag of the previous one.
   task automatic predict_tick(input logic down_raw, input logic up, input logic power,
                               input logic [DELTA_W-1:0] elapsed);
      logic [NUM_KEYS-1:0]   lvl;
      logic [TIME_WIDTH:0]   sum;
      logic [TIME_WIDTH:0]   step;
      logic [TIME_WIDTH-1:0] t;
      key_code_type          hits[$];
      rsp_entry_type         entry;
      lvl  = {power, up, down_raw ^ low_cfg};
      step = {{(TIME_WIDTH + 1 - DELTA_W){1'b0}}, elapsed};
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (en_cfg[k]) begin
            down_flag[k] = lvl[k];
            sum = {1'b0, held[k]} + step;
            t = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
            held[k] = t;
            case (phase[k])
               PHASE_PRESSED: begin
                  if (lvl[k]) begin
                     if (repeating[k] && t >= repeat_cfg) begin
                        hits.push_back(short_code(k));
                        held[k] = '0;
                     end else if (!long_seen[k] && t >= longpress_cfg) begin
                        if (k == POWER_KEY) begin
                           if (down_flag[DOWN_KEY]) hits.push_back(CODE_S);
                           else if (down_flag[UP_KEY]) hits.push_back(CODE_E);
                           else hits.push_back(CODE_SPACE);
                        end else if (!down_flag[POWER_KEY]) begin
                           hits.push_back(short_code(k));
                           held[k]      = '0;
                           repeating[k] = 1'b1;
                        end
                        long_seen[k] = 1'b1;
                     end
                  end else if (!long_seen[k]) begin
                     hits.push_back(short_code(k));
                     phase[k] = PHASE_PENDING;
                  end else if (t >= guard_cfg) begin
                     clear_key(k);
                  end
               end
               PHASE_PENDING: begin
                  // back to released whatever the level
                  clear_key(k);
               end
               default: begin
                  if (lvl[k]) begin
                     held[k]  = '0;
                     phase[k] = PHASE_PRESSED;
                  end else begin
                     phase[k] = PHASE_RELEASED;
                  end
               end
            endcase
         end
      end
      for (int i = 0; i < hits.size(); i++) begin
         entry.code = hits[i];
         entry.last = (i == hits.size() - 1);
         due_reports.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         en_cfg        = RST_KEY_ENABLE;
         low_cfg       = RST_DOWN_ACTIVE_LOW;
         repeat_cfg    = RST_REPEAT_INTERVAL;
         longpress_cfg = RST_LONGPRESS;
         guard_cfg     = RST_RELEASE_GUARD;
         for (int k = 0; k < NUM_KEYS; k++) begin
            clear_key(k);
         end
         down_flag = '0;
         due_reports.delete();
      end else begin
         // a report leaves in the cycle after its tick at the earliest
         if (rsp_valid && rsp_ready) begin
            got.code = rsp_key_code;
            got.last = rsp_last;
            if (due_reports.size() == 0) begin
               note_fail($sformatf("unexpected report: code %0d last %0b", got.code, got.last));
            end else begin
               want = due_reports.pop_front();
               if (got.code !== want.code || got.last !== want.last) begin
                  note_fail($sformatf("report: expected code %0d last %0b, got code %0d last %0b",
                                      want.code, want.last, got.code, got.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_tick(req_down_level, req_up_pressed, req_power_pressed, req_elapsed_ns);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_KEY_ENABLE:      en_cfg        = csr_pwdata[NUM_KEYS-1:0];
               REG_DOWN_ACTIVE_LOW: low_cfg       = csr_pwdata[0];
               REG_REPEAT_INTERVAL: repeat_cfg    = csr_pwdata;
               REG_LONGPRESS:       longpress_cfg = csr_pwdata;
               REG_RELEASE_GUARD:   guard_cfg     = csr_pwdata;
               default: ;
            endcase
         end
      end
      reports_due <= due_reports.size();
   end

endmodule

// File: bench/tb_three_key_longpress_repeat_combo.sv
module tb_three_key_longpress_repeat_combo;
   timeunit 1ns;
   timeprecision 1ps;
   import tklrc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_STALL     = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_TICKS     = 50;
   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    reports_due;
   idle_mode_type         idle_mode;
   int                    stall_len;
   logic                  down_low_cfg;
   int                    quiet_cycles;

   tklrc_req_if req_bus();
   tklrc_rsp_if rsp_bus();

   three_key_longpress_repeat_combo i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   key_report_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_down_level    (req_bus.down_level),
      .req_up_pressed    (req_bus.up_pressed),
      .req_power_pressed (req_bus.power_pressed),
      .req_elapsed_ns    (req_bus.elapsed_ns),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_key_code      (rsp_bus.key_code),
      .rsp_last          (rsp_bus.last),
      .csr_psel          (psel),
      .csr_penable       (penable),
      .csr_pwrite        (pwrite),
      .csr_pready        (pready),
      .csr_paddr         (paddr),
      .csr_pwdata        (pwdata),
      .fail_count        (fail_count),
      .reports_due       (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: a long hold-off takes precedence over the random stalls
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_len > 0) begin
            stall_len--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (idle_mode)
               IDLE_RECEIVER: rsp_bus.ready = ($urandom_range(0, 99) >= 80);
               IDLE_BOTH:     rsp_bus.ready = ($urandom_range(0, 99) >= 25);
               default:       rsp_bus.ready = 1'b1;
            endcase
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (psel && penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("three_key_longpress_repeat_combo test failed");
      $finish;
   end

   function automatic logic sender_waits();
      case (idle_mode)
         IDLE_SENDER: return ($urandom_range(0, 99) < 80);
         IDLE_BOTH:   return ($urandom_range(0, 99) < 25);
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic [31:0] pick_elapsed(input logic [31:0] span);
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         default: return $urandom_range(0, span);
      endcase
   endfunction

   // lv = {power, up, down} as pressed levels; down goes out as its raw level
   task automatic send_levels(input logic [2:0] lv, input logic [31:0] elapsed);
      @(negedge clock);
      while (sender_waits()) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.down_level    = lv[0] ^ down_low_cfg;
      req_bus.up_pressed    = lv[1];
      req_bus.power_pressed = lv[2];
      req_bus.elapsed_ns    = elapsed;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (reports_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic [2:0] en, input logic low, input logic [31:0] rep,
                             input logic [31:0] lp, input logic [31:0] guard);
      wait_drained();
      csr_write(REG_KEY_ENABLE, {29'd0, en});
      csr_write(REG_DOWN_ACTIVE_LOW, {31'd0, low});
      csr_write(REG_REPEAT_INTERVAL, rep);
      csr_write(REG_LONGPRESS, lp);
      csr_write(REG_RELEASE_GUARD, guard);
      down_low_cfg = low;
   endtask

   // mostly press/hold/release gestures, some ticks of random levels
   task automatic play_gestures(input int n_items, input logic [31:0] span);
      int         sent;
      int         hold;
      int         tail;
      int         flip;
      logic [2:0] mask;
      logic [2:0] lv;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 4) == 0) begin
            send_levels(3'($urandom_range(0, 7)), pick_elapsed(span));
            sent++;
         end else begin
            mask = 3'($urandom_range(1, 7));
            hold = $urandom_range(1, 8);
            tail = $urandom_range(1, 3);
            for (int i = 0; i < hold; i++) begin
               lv = mask;
               // staggered starts let combos begin in either key order
               if ((i == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 9) == 0) begin
                  flip = $urandom_range(0, 2);
                  lv[flip] = ~lv[flip];
               end
               send_levels(lv, pick_elapsed(span));
               sent++;
            end
            for (int i = 0; i < tail; i++) begin
               send_levels(3'b000, pick_elapsed(span));
               sent++;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [2:0] en, input logic low, input logic [31:0] rep,
                            input logic [31:0] lp, input logic [31:0] guard,
                            input idle_mode_type mode, input int n_items,
                            input logic [31:0] span);
      set_config(en, low, rep, lp, guard);
      idle_mode = mode;
      play_gestures(n_items, span);
   endtask

   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.down_level    = 1'b0;
      req_bus.up_pressed    = 1'b0;
      req_bus.power_pressed = 1'b0;
      req_bus.elapsed_ns    = '0;
      idle_mode             = IDLE_NONE;
      stall_len             = 0;
      down_low_cfg          = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset configuration
      send_levels(3'b000, 32'd0);
      // short down press, then a press on the pending tick is dropped
      send_levels(3'b001, 32'd0);
      send_levels(3'b000, 32'd5);
      send_levels(3'b001, 32'd0);
      send_levels(3'b000, 32'd0);
      // up long press into autorepeat, release inside and past the guard
      send_levels(3'b010, 32'd0);
      send_levels(3'b010, '1);
      send_levels(3'b010, '1);
      send_levels(3'b000, 32'd0);
      send_levels(3'b000, '1);
      // power combos: with down, with up, alone
      send_levels(3'b101, 32'd0);
      send_levels(3'b101, '1);
      send_levels(3'b000, '1);
      send_levels(3'b110, 32'd0);
      send_levels(3'b110, '1);
      send_levels(3'b000, '1);
      send_levels(3'b100, 32'd0);
      send_levels(3'b100, '1);
      send_levels(3'b000, '1);
      // three short presses reported in one tick
      send_levels(3'b111, 32'd0);
      send_levels(3'b000, 32'd1);
      send_levels(3'b000, 32'd0);

      wait_drained();
      csr_write(REG_SPARE_FIRST, $urandom);
      csr_write(REG_SPARE_LAST, $urandom);
      idle_mode = IDLE_NONE;
      play_gestures(15, 32'd400);

      run_phase(3'b111, 1'b0, 32'd300, 32'd1000, 32'd100, IDLE_NONE, 25, 32'd400);
      run_phase(3'b111, 1'b1, 32'd300, 32'd1000, 32'd100, IDLE_SENDER, 25, 32'd400);
      run_phase(3'b101, 1'b0, 32'd0, 32'd0, 32'd0, IDLE_RECEIVER, 20, 32'd50);
      run_phase(3'b011, 1'b1, '1, '1, '1, IDLE_BOTH, 20, '1);
      run_phase(3'b000, 1'b0, 32'd300, 32'd1000, 32'd100, IDLE_NONE, 6, 32'd400);
      run_phase(3'b110, 1'b1, 32'd150, 32'd600, 32'd50, IDLE_BOTH, 25, 32'd250);
      run_phase(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 1500), $urandom_range(0, 3000), $urandom_range(0, 500),
                IDLE_RECEIVER, 25, 32'd600);

      // fill the result queue behind a long receiver hold-off
      set_config(3'b111, 1'b0, 32'd0, 32'd0, 32'd0);
      idle_mode = IDLE_NONE;
      @(posedge clock);
      stall_len = LONG_STALL;
      repeat (24) send_levels(3'b011, pick_elapsed(32'd100));
      send_levels(3'b000, 32'd0);
      wait_drained();
      play_gestures(10, 32'd20);

      // hold all keys through a long run of maximal steps
      set_config(3'b111, 1'b0, 32'd200000000, 32'd0, '1);
      idle_mode = IDLE_BOTH;
      repeat (HOLD_TICKS) send_levels(3'b111, '1);
      send_levels(3'b000, 32'd0);
      send_levels(3'b000, 32'd0);
      idle_mode = IDLE_NONE;
      play_gestures(10, '1);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && reports_due == 0) begin
         $display("three_key_longpress_repeat_combo test passed");
      end else begin
         $display("three_key_longpress_repeat_combo test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/tklrc_pkg.sv
hw/rtl/tklrc_if.sv
hw/rtl/tklrc_lane.sv
hw/rtl/tklrc_merge.sv
hw/rtl/three_key_longpress_repeat_combo.sv
bench/key_report_checker.sv
bench/tb_three_key_longpress_repeat_combo.sv
